[hw/rtl/dlcd_pkg.sv]
// ----------------------------------------------------------------------------
// dlcd_pkg
// Types, register indexes and helper functions shared by the directed line
// crossing detector.
// ----------------------------------------------------------------------------
package dlcd_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 1;
  localparam int CfgIdxW = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;

  localparam cfg_idx_t REG_LINE_START_X = 3'd0;
  localparam cfg_idx_t REG_LINE_START_Y = 3'd1;
  localparam cfg_idx_t REG_LINE_END_X   = 3'd2;
  localparam cfg_idx_t REG_LINE_END_Y   = 3'd3;
  localparam cfg_idx_t REG_HEADING_X    = 3'd4;
  localparam cfg_idx_t REG_HEADING_Y    = 3'd5;

  localparam coord_t HEADING_X_RESET = coord_t'(4096);

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
  } in_item_t;

  typedef struct packed {
    logic crossed;
    logic moving_forward;
    logic segments_meet;
  } out_item_t;

  // orientation sign: neg set for negative, nz set for non-zero
  typedef struct packed {
    logic neg;
    logic nz;
  } orient_t;

  // differences of the move and the start line, stage one
  typedef struct packed {
    diff_t      mx;
    diff_t      my;
    diff_t      slx;
    diff_t      sly;
    diff_t      elx;
    diff_t      ely;
    diff_t      dex;
    diff_t      dey;
    diff_t      lsx;
    diff_t      lsy;
    diff_t      csx;
    diff_t      csy;
    logic [3:0] box;
    logic       has_prev;
  } diff_set_t;

  // products, stage two
  typedef struct packed {
    prod_t      o1p;
    prod_t      o1q;
    prod_t      o2p;
    prod_t      o2q;
    prod_t      o3p;
    prod_t      o3q;
    prod_t      o4p;
    prod_t      o4q;
    prod_t      dpx;
    prod_t      dpy;
    logic [3:0] box;
    logic       has_prev;
  } prod_set_t;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic logic between(coord_t a, coord_t b, coord_t p);
    return ((p >= a) && (p <= b)) || ((p >= b) && (p <= a));
  endfunction

  function automatic prod_t mul_d(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic orient_t orient_sign(prod_t p, prod_t q);
    sum_t    d;
    orient_t o;
    d     = sum_t'(p) - sum_t'(q);
    o.neg = d[SumW-1];
    o.nz  = (d != '0);
    return o;
  endfunction

endpackage

[hw/rtl/dlcd_mul.sv]
// ----------------------------------------------------------------------------
// dlcd_mul
// Product stage: forms the ten exact orientation and heading products and
// registers them.
// ----------------------------------------------------------------------------
module dlcd_mul import dlcd_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  diff_set_t diff_i,
  input  coord_t    heading_x,
  input  coord_t    heading_y,
  output prod_set_t prod_o
);

  prod_set_t prod_r;
  prod_set_t prod_nxt;

  always_comb begin
    prod_nxt.o1p      = mul_d(diff_i.mx, diff_i.sly);
    prod_nxt.o1q      = mul_d(diff_i.my, diff_i.slx);
    prod_nxt.o2p      = mul_d(diff_i.mx, diff_i.ely);
    prod_nxt.o2q      = mul_d(diff_i.my, diff_i.elx);
    prod_nxt.o3p      = mul_d(diff_i.dex, diff_i.lsy);
    prod_nxt.o3q      = mul_d(diff_i.dey, diff_i.lsx);
    prod_nxt.o4p      = mul_d(diff_i.dex, diff_i.csy);
    prod_nxt.o4q      = mul_d(diff_i.dey, diff_i.csx);
    prod_nxt.dpx      = mul_d(diff_i.mx, diff_t'(heading_x));
    prod_nxt.dpy      = mul_d(diff_i.my, diff_t'(heading_y));
    prod_nxt.box      = diff_i.box;
    prod_nxt.has_prev = diff_i.has_prev;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_o = prod_r;

endmodule

[hw/rtl/directed_line_crossing_detector.sv]
// ----------------------------------------------------------------------------
// directed_line_crossing_detector
// Flags forward crossings of a configured start line by a stream of signed
// Q12.12 position samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one position sample per item (valid/ready).
//   out_* : one result per sample, in order (valid/ready).
//   cfg_* : write enable, register index and data; write only while idle.
// Each result compares the move from the previous sample to this one with
// the start line and the heading vector. The first sample after reset is
// only stored and yields an all-zero result.
// Each result passes through three registers after the edge that accepts
// its input: a difference register, a product register and the result
// register. Throughput is one item per cycle while the receiver does not
// stall; the three stages advance together.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// only while the result register is full and not being taken.
// Reset clears all valid flags and the previous-sample flag, and returns
// the registers to a zero line with heading (1.0, 0).
// ----------------------------------------------------------------------------
module directed_line_crossing_detector import dlcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_idx,
  input  coord_t    cfg_wdata
);

  coord_t    line_sx_r, line_sy_r, line_ex_r, line_ey_r, head_x_r, head_y_r;
  coord_t    last_x_r, last_y_r;
  logic      last_valid_r;
  logic      s1_valid_r, s2_valid_r, out_valid_r;
  diff_set_t s1_r, s1_nxt;
  prod_set_t s2;
  out_item_t out_r, out_nxt;
  logic      pipe_en, in_acc;
  orient_t   o1, o2, o3, o4, dot;
  logic      hit, fwd;

  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;
  assign in_acc   = in_valid && pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_sx_r <= '0;
      line_sy_r <= '0;
      line_ex_r <= '0;
      line_ey_r <= '0;
      head_x_r  <= HEADING_X_RESET;
      head_y_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LINE_START_X: line_sx_r <= cfg_wdata;
        REG_LINE_START_Y: line_sy_r <= cfg_wdata;
        REG_LINE_END_X:   line_ex_r <= cfg_wdata;
        REG_LINE_END_Y:   line_ey_r <= cfg_wdata;
        REG_HEADING_X:    head_x_r  <= cfg_wdata;
        REG_HEADING_Y:    head_y_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_nxt.mx       = sub_c(in_data.pos_x, last_x_r);
    s1_nxt.my       = sub_c(in_data.pos_y, last_y_r);
    s1_nxt.slx      = sub_c(line_sx_r, last_x_r);
    s1_nxt.sly      = sub_c(line_sy_r, last_y_r);
    s1_nxt.elx      = sub_c(line_ex_r, last_x_r);
    s1_nxt.ely      = sub_c(line_ey_r, last_y_r);
    s1_nxt.dex      = sub_c(line_ex_r, line_sx_r);
    s1_nxt.dey      = sub_c(line_ey_r, line_sy_r);
    s1_nxt.lsx      = sub_c(last_x_r, line_sx_r);
    s1_nxt.lsy      = sub_c(last_y_r, line_sy_r);
    s1_nxt.csx      = sub_c(in_data.pos_x, line_sx_r);
    s1_nxt.csy      = sub_c(in_data.pos_y, line_sy_r);
    s1_nxt.box[0]   = between(last_x_r, in_data.pos_x, line_sx_r) &&
                      between(last_y_r, in_data.pos_y, line_sy_r);
    s1_nxt.box[1]   = between(last_x_r, in_data.pos_x, line_ex_r) &&
                      between(last_y_r, in_data.pos_y, line_ey_r);
    s1_nxt.box[2]   = between(line_sx_r, line_ex_r, last_x_r) &&
                      between(line_sy_r, line_ey_r, last_y_r);
    s1_nxt.box[3]   = between(line_sx_r, line_ex_r, in_data.pos_x) &&
                      between(line_sy_r, line_ey_r, in_data.pos_y);
    s1_nxt.has_prev = last_valid_r;
  end

  // hold the previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= 1'b0;
    end else if (in_acc) begin
      last_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_x_r <= in_data.pos_x;
      last_y_r <= in_data.pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r  <= in_acc;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_r  <= s1_nxt;
      out_r <= out_nxt;
    end
  end

  dlcd_mul u_mul (
    .clk       (clk),
    .en        (pipe_en),
    .diff_i    (s1_r),
    .heading_x (head_x_r),
    .heading_y (head_y_r),
    .prod_o    (s2)
  );

  always_comb begin
    o1  = orient_sign(s2.o1p, s2.o1q);
    o2  = orient_sign(s2.o2p, s2.o2q);
    o3  = orient_sign(s2.o3p, s2.o3q);
    o4  = orient_sign(s2.o4p, s2.o4q);
    dot = orient_sign(s2.dpx, -s2.dpy);
    hit = ((o1 != o2) && (o3 != o4)) ||
          (!o1.nz && s2.box[0]) || (!o2.nz && s2.box[1]) ||
          (!o3.nz && s2.box[2]) || (!o4.nz && s2.box[3]);
    fwd = dot.nz && !dot.neg;
    out_nxt.segments_meet  = s2.has_prev && hit;
    out_nxt.moving_forward = s2.has_prev && fwd;
    out_nxt.crossed        = s2.has_prev && hit && fwd;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(s1_valid_r) && $stable(s2_valid_r) && $stable(s1_r))
    else $error("pipeline advanced during a stall");

  a_prev_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> last_valid_r && s1_valid_r)
    else $error("accepted item not stored");

  a_first_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !last_valid_r) |=> ##2 (out_valid_r && out_r == '0))
    else $error("first item after reset gave a non-zero result");

endmodule
